// File: design/tmrc_pkg.sv
package tmrc_pkg;

  // Widths of the request and result fields and of the control register.
  localparam int LINE_W     = 4;
  localparam int VERDICT_W  = 2;
  localparam int CFG_W      = 6;
  localparam int LINE_COUNT = 6;

  // Bit positions inside one machine line.
  localparam int LINE_PRINT = 3;
  localparam int LINE_RIGHT = 2;

  // Reset value of the shift limit register.
  localparam logic [CFG_W-1:0] MAX_SHIFTS_RST = 6'd50;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_NONE    = 2'd0,
    VERDICT_LOOPED  = 2'd1,
    VERDICT_SPILLED = 2'd2,
    VERDICT_STOPPED = 2'd3
  } verdict_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_STEP = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

endpackage

// File: design/tmrc_in_if.sv
interface tmrc_in_if
  import tmrc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line_a0;
  logic [LINE_W-1:0] line_a1;
  logic [LINE_W-1:0] line_b0;
  logic [LINE_W-1:0] line_b1;
  logic [LINE_W-1:0] line_c0;
  logic [LINE_W-1:0] line_c1;

  modport source (output valid, line_a0, line_a1, line_b0, line_b1, line_c0, line_c1,
                  input ready);
  modport sink (input valid, line_a0, line_a1, line_b0, line_b1, line_c0, line_c1,
                output ready);
endinterface

// File: design/tmrc_out_if.sv
interface tmrc_out_if
  import tmrc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

// File: design/tmrc_snap_mem.sv
module tmrc_snap_mem #(
  parameter int DEPTH  = 51,
  parameter int DATA_W = 45
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data_r
);

  logic [DATA_W-1:0] mem_r [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

// File: design/tmrc_cmp.sv
module tmrc_cmp #(
  parameter int DEVIATION_LIMIT = 17,
  parameter int W               = 36,
  parameter int DW              = 6
) (
  input  logic [W-1:0]         old_tape,
  input  logic [W-1:0]         new_tape,
  input  logic signed [DW-1:0] old_dev,
  input  logic signed [DW-1:0] new_dev,
  input  logic signed [DW-1:0] span_lo,
  input  logic signed [DW-1:0] span_hi,
  output logic                 match
);

  localparam int PW    = DW + 2;
  localparam int START = DEVIATION_LIMIT + 1;

  logic signed [DW:0]   delta;
  logic [DW:0]          amt;
  logic signed [PW-1:0] lo_pos;
  logic signed [PW-1:0] hi_pos;
  logic [W-1:0]         shifted;
  logic [W-1:0]         mask;

  // Align the new tape with the old one and pick the window between the barriers.
  always_comb begin
    delta = (DW+1)'(new_dev) - (DW+1)'(old_dev);
    if (delta > 0) begin
      amt     = delta;
      shifted = new_tape >> amt;
      lo_pos  = PW'(START) + PW'(span_lo);
      hi_pos  = PW'(START + DEVIATION_LIMIT) - PW'(delta);
    end else if (delta < 0) begin
      amt     = -delta;
      shifted = new_tape << amt;
      lo_pos  = PW'(START - DEVIATION_LIMIT) - PW'(delta);
      hi_pos  = PW'(START) + PW'(span_hi);
    end else begin
      amt     = '0;
      shifted = new_tape;
      lo_pos  = PW'(START) + PW'(span_lo);
      hi_pos  = PW'(START) + PW'(span_hi);
    end
  end

  // Mask each bit position independently.
  always_comb begin
    for (int i = 0; i < W; i++) begin
      mask[i] = (PW'(i) >= lo_pos) && (PW'(i) <= hi_pos);
    end
  end

  // An empty window never matches.
  assign match = (lo_pos <= hi_pos) && (((old_tape ^ shifted) & mask) == '0);

endmodule

// File: design/tm_partial_recurrence_check.sv
// Runs one 3-card binary Turing machine per request and reports a verdict.
// The in_req channel carries the six 4-bit machine lines; a request is taken
// on a clock edge where valid and ready are both high. Ready is high only
// while the block is idle. The out_res channel carries a 2-bit verdict: no
// recurrence, looped, spilled past the tape word, or stopped.
// The cfg port writes the shift limit (reset value 50) whenever cfg_we is high;
// write it only while the block is idle.
// Each step of the machine is followed by a scan: the new snapshot is checked
// against the earlier snapshots, until one matches, through one shared
// shifted compare unit fed by the registered snapshot memory read port, one
// snapshot per cycle. A scan without a match returns to the next step.
// The verdict sits in an output register until the receiver takes it; a
// stalled receiver holds the block, and no new request is taken until then.
// Synchronous reset clears the sequencer and restores the shift limit; the
// snapshot memory needs no clearing since each row is written before it is compared.
module tm_partial_recurrence_check
  import tmrc_pkg::*;
#(
  parameter int SHIFT_BOUND     = 50,
  parameter int DEVIATION_LIMIT = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  tmrc_in_if.sink          in_req,
  tmrc_out_if.source       out_res,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int START = DEVIATION_LIMIT + 1;
  localparam int W     = 2 * DEVIATION_LIMIT + 2;
  localparam int DW    = $clog2(DEVIATION_LIMIT + 2) + 1;
  localparam int SW    = $clog2(SHIFT_BOUND + 2);
  localparam int AW    = $clog2(SHIFT_BOUND + 1);
  localparam int XW    = $clog2(W);
  localparam int RW    = W + 3 + DW;

  state_t                       state_r, state_nxt;
  logic [CFG_W-1:0]             max_shifts_r;
  logic [LINE_COUNT-1:0][LINE_W-1:0] lines_r;
  logic [W-1:0]                 tape_r, tape_nxt;
  logic signed [DW-1:0]         dev_r, dev_nxt;
  logic [1:0]                   card_r, card_nxt;
  logic [SW-1:0]                s_r, s_nxt;
  logic [SW-1:0]                k_r, k_nxt;
  logic                         pend_r, pend_nxt;
  logic signed [DW-1:0]         mn_r, mn_nxt, mx_r, mx_nxt;
  logic [2:0]                   bkt_r, bkt_nxt;
  verdict_t                     verdict_r, verdict_nxt;

  // Step datapath.
  logic signed [DW+1:0] pos, pos_new;
  logic                 scanned, scanned_new;
  logic [LINE_W-1:0]    line;
  logic [W-1:0]         tape_step;
  logic signed [DW-1:0] dev_step;
  logic                 limit_hit;
  logic                 spill;

  // Scan datapath.
  logic                 wr_en;
  logic [AW-1:0]        rd_addr;
  logic [RW-1:0]        rd_row;
  logic [W-1:0]         old_tape;
  logic [2:0]           old_bkt;
  logic signed [DW-1:0] old_dev;
  logic signed [DW-1:0] mn_cur, mx_cur;
  logic                 match;

  // Fetch the line for the current card and scanned bit, then apply it.
  always_comb begin
    pos       = (DW+2)'(START) + (DW+2)'(dev_r);
    scanned   = tape_r[pos[XW-1:0]];
    case ({card_r, scanned})
      3'b010:  line = lines_r[0];
      3'b011:  line = lines_r[1];
      3'b100:  line = lines_r[2];
      3'b101:  line = lines_r[3];
      3'b110:  line = lines_r[4];
      3'b111:  line = lines_r[5];
      default: line = lines_r[0];
    endcase
    tape_step              = tape_r;
    tape_step[pos[XW-1:0]] = line[LINE_PRINT];
    dev_step    = line[LINE_RIGHT] ? dev_r + DW'(1) : dev_r - DW'(1);
    spill       = (dev_step > DW'(DEVIATION_LIMIT)) || (dev_step < -DW'(DEVIATION_LIMIT));
    pos_new     = (DW+2)'(START) + (DW+2)'(dev_step);
    scanned_new = tape_step[pos_new[XW-1:0]];
    limit_hit   = (8'(s_r) > 8'(max_shifts_r)) || (8'(s_r) > 8'(SHIFT_BOUND));
  end

  // Snapshot row fields and the running span of the head since that row.
  assign {old_tape, old_bkt, old_dev} = rd_row;
  assign mn_cur  = (old_dev < mn_r) ? old_dev : mn_r;
  assign mx_cur  = (old_dev > mx_r) ? old_dev : mx_r;
  assign rd_addr = k_r[AW-1:0];
  assign wr_en   = (state_r == ST_STEP) && !limit_hit && (line[1:0] != 2'd0) && !spill;

  tmrc_snap_mem #(
    .DEPTH  (SHIFT_BOUND + 1),
    .DATA_W (RW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (s_r[AW-1:0]),
    .wr_data   ({tape_step, {line[1:0] - 2'd1, scanned_new}, dev_step}),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_row)
  );

  tmrc_cmp #(
    .DEVIATION_LIMIT (DEVIATION_LIMIT),
    .W               (W),
    .DW              (DW)
  ) u_cmp (
    .old_tape (old_tape),
    .new_tape (tape_r),
    .old_dev  (old_dev),
    .new_dev  (dev_r),
    .span_lo  (mn_cur),
    .span_hi  (mx_cur),
    .match    (match)
  );

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    tape_nxt    = tape_r;
    dev_nxt     = dev_r;
    card_nxt    = card_r;
    s_nxt       = s_r;
    k_nxt       = k_r;
    pend_nxt    = 1'b0;
    mn_nxt      = mn_r;
    mx_nxt      = mx_r;
    bkt_nxt     = bkt_r;
    verdict_nxt = verdict_r;
    case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          state_nxt = ST_STEP;
          tape_nxt  = '0;
          dev_nxt   = '0;
          card_nxt  = 2'd1;
          s_nxt     = SW'(1);
        end
      end
      ST_STEP: begin
        if (limit_hit) begin
          verdict_nxt = VERDICT_NONE;
          state_nxt   = ST_OUT;
        end else if (line[1:0] == 2'd0) begin
          verdict_nxt = VERDICT_STOPPED;
          state_nxt   = ST_OUT;
        end else if (spill) begin
          verdict_nxt = VERDICT_SPILLED;
          state_nxt   = ST_OUT;
        end else begin
          tape_nxt  = tape_step;
          dev_nxt   = dev_step;
          card_nxt  = line[1:0];
          bkt_nxt   = {line[1:0] - 2'd1, scanned_new};
          mn_nxt    = dev_step;
          mx_nxt    = dev_step;
          k_nxt     = s_r - SW'(1);
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Issue the next older row while the previous one is compared.
        if (k_r != '0) begin
          k_nxt    = k_r - SW'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          mn_nxt = mn_cur;
          mx_nxt = mx_cur;
        end
        if (pend_r && (old_bkt == bkt_r) && match) begin
          // A match ends the scan, so no read stays in flight.
          pend_nxt    = 1'b0;
          verdict_nxt = VERDICT_LOOPED;
          state_nxt   = ST_OUT;
        end else if ((k_r == '0) && !pend_r) begin
          s_nxt     = s_r + SW'(1);
          state_nxt = ST_STEP;
        end
      end
      ST_OUT: begin
        if (out_res.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      max_shifts_r <= MAX_SHIFTS_RST;
      pend_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      if (cfg_we) begin
        max_shifts_r <= cfg_wdata;
      end
    end
  end

  // Working registers of the running machine.
  always_ff @(posedge clk) begin
    tape_r    <= tape_nxt;
    dev_r     <= dev_nxt;
    card_r    <= card_nxt;
    s_r       <= s_nxt;
    k_r       <= k_nxt;
    mn_r      <= mn_nxt;
    mx_r      <= mx_nxt;
    bkt_r     <= bkt_nxt;
    verdict_r <= verdict_nxt;
    if (state_r == ST_IDLE && in_req.valid) begin
      lines_r <= {in_req.line_c1, in_req.line_c0, in_req.line_b1,
                  in_req.line_b0, in_req.line_a1, in_req.line_a0};
    end
  end

  assign in_req.ready    = (state_r == ST_IDLE);
  assign out_res.valid   = (state_r == ST_OUT);
  assign out_res.verdict = verdict_r;

  // The scan only visits rows logged at earlier steps.
  a_scan_older: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (k_r < s_r))
    else $error("scan index reached the current step");

  // A scanned head position always lies inside the tape word.
  a_dev_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ((dev_r <= DW'(DEVIATION_LIMIT)) &&
                              (dev_r >= -DW'(DEVIATION_LIMIT))))
    else $error("head deviation out of range during scan");

  // A pending read is only ever in flight during a scan.
  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_SCAN))
    else $error("snapshot read outside of a scan");

  // A new machine always starts with a step.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> (state_r == ST_STEP))
    else $error("accepted request did not start a step");

endmodule
